@@ design/sprite_line_selector_defines.svh @@
`ifndef SPRITE_LINE_SELECTOR_DEFINES_SVH
`define SPRITE_LINE_SELECTOR_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sls_pkg.sv @@
package sls_pkg;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] tile;
    logic [7:0] attrs;
  } sprite_t;

  localparam int SpriteW = $bits(sprite_t);

  // Compare unit controls from the sequencer
  typedef struct packed {
    logic clear;
    logic vld;
    logic skip;
    logic by_x;
  } pick_ctrl_t;

  localparam logic [7:0] ROW_LIMIT = 8'd160;
  localparam logic [7:0] X_LIMIT   = 8'd168;
  localparam logic [8:0] Y_SPAN    = 9'd16;
  localparam logic [7:0] GAP_SHORT = 8'h08;
  localparam logic [7:0] TILE_MASK = 8'hFE;

  // Configuration register indexes
  localparam logic CFG_TALL  = 1'b0;
  localparam logic CFG_COLOR = 1'b1;

endpackage

@@ design/sprite_line_selector.sv @@
// Sprite line selector. Table entries arrive one beat per cycle together with the
// line being searched; the first MAX_PER_LINE entries that cover the line are
// counted and those with a visible X are stored. The beat flagged last_entry
// starts the output phase, during which no input is taken: for every result one
// compare unit walks all kept sprites through the single read port of the sprite
// RAM in the scan state; the drain and load states follow, and the emit state holds
// the result until out_ready_i takes it. Classic mode emits by descending X, ties
// in falling table order; color mode emits in falling table order. A line with no
// kept sprite gives a single beat with any_sprite_o low and last_sprite_o high.
`include "sprite_line_selector_defines.svh"

module sprite_line_selector import sls_pkg::*; #(
  parameter int MAX_PER_LINE = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] line_i,
  input  logic [7:0] entry_y_i,
  input  logic [7:0] entry_x_i,
  input  logic [7:0] entry_tile_i,
  input  logic [7:0] entry_attrs_i,
  input  logic       last_entry_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       any_sprite_o,
  output logic [7:0] sprite_y_o,
  output logic [7:0] sprite_x_o,
  output logic [7:0] tile_num_o,
  output logic       bg_priority_o,
  output logic       flip_vertical_o,
  output logic       flip_horizontal_o,
  output logic [2:0] palette_number_o,
  output logic       bank_number_o,
  output logic       last_sprite_o
);

  localparam int IW = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1;
  localparam int CW = $clog2(MAX_PER_LINE + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]              state_q, state_d;
  logic                    tall_q, color_q;
  logic [CW-1:0]           kept_q, kept_d, hit_q, hit_d, rem_q, rem_d;
  logic [IW-1:0]           scan_q, scan_d, cmp_idx_q;
  logic                    cmp_vld_q, cmp_vld_d;
  logic [MAX_PER_LINE-1:0] emitted_q, emitted_d;
  logic                    out_valid_q, out_valid_d;
  logic                    load_out, load_empty, ram_we;

  logic       any_q, behind_q, flipv_q, fliph_q, bank_q, last_q;
  logic [7:0] y_q, x_q, tile_q;
  logic [2:0] pal_q;

  logic       in_fire, out_fire, hit, keep;
  logic [7:0] gap, y_top;
  sprite_t    wr_entry, rd_entry, best;
  logic [IW-1:0] best_idx;
  logic       have_best;
  pick_ctrl_t pick_ctrl;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // Coverage test for this entry
  assign gap   = tall_q ? 8'd0 : GAP_SHORT;
  assign y_top = entry_y_i - gap;
  assign hit   = (hit_q < CW'(MAX_PER_LINE)) && (entry_y_i > gap) &&
                 (entry_y_i < ROW_LIMIT) && (line_i < y_top) &&
                 (({1'b0, line_i} + Y_SPAN) >= {1'b0, entry_y_i});
  assign keep  = hit && (entry_x_i != 8'd0) && (entry_x_i < X_LIMIT) &&
                 (kept_q < CW'(MAX_PER_LINE));

  assign wr_entry.y     = entry_y_i;
  assign wr_entry.x     = entry_x_i;
  assign wr_entry.tile  = tall_q ? (entry_tile_i & TILE_MASK) : entry_tile_i;
  assign wr_entry.attrs = entry_attrs_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tall_q  <= 1'b0;
      color_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TALL:  tall_q  <= cfg_data_i;
        CFG_COLOR: color_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    kept_d      = kept_q;
    hit_d       = hit_q;
    scan_d      = scan_q;
    rem_d       = rem_q;
    emitted_d   = emitted_q;
    out_valid_d = out_valid_q;
    cmp_vld_d   = 1'b0;
    load_out    = 1'b0;
    load_empty  = 1'b0;
    ram_we      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (hit) begin
            hit_d = hit_q + CW'(1);
          end
          if (keep) begin
            ram_we = 1'b1;
            kept_d = kept_q + CW'(1);
          end
          if (last_entry_i) begin
            if (kept_d == '0) begin
              load_empty  = 1'b1;
              out_valid_d = 1'b1;
              hit_d       = '0;
              state_d     = ST_EMIT;
            end else begin
              rem_d   = kept_d;
              scan_d  = IW'(kept_d - CW'(1));
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        // Walk kept slots from the top down, one RAM read a cycle
        cmp_vld_d = 1'b1;
        if (scan_q == '0) begin
          state_d = ST_DRAIN;
        end else begin
          scan_d = scan_q - IW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
        rem_d       = rem_q - CW'(1);
        emitted_d   = emitted_q | (MAX_PER_LINE'(1) << best_idx);
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_fire) begin
          out_valid_d = 1'b0;
          if (last_q) begin
            kept_d    = '0;
            hit_d     = '0;
            emitted_d = '0;
            state_d   = ST_IDLE;
          end else begin
            scan_d  = IW'(kept_q - CW'(1));
            state_d = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kept_q      <= '0;
      hit_q       <= '0;
      scan_q      <= '0;
      rem_q       <= '0;
      emitted_q   <= '0;
      out_valid_q <= 1'b0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
    end else begin
      state_q     <= state_d;
      kept_q      <= kept_d;
      hit_q       <= hit_d;
      scan_q      <= scan_d;
      rem_q       <= rem_d;
      emitted_q   <= emitted_d;
      out_valid_q <= out_valid_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_idx_q   <= scan_q;
    end
  end

  sls_ram #(
    .WIDTH (SpriteW),
    .DEPTH (MAX_PER_LINE),
    .AW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (kept_q[IW-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (scan_q),
    .rdata_o (rd_entry)
  );

  assign pick_ctrl.clear = (state_q == ST_IDLE) || (state_q == ST_EMIT);
  assign pick_ctrl.vld   = cmp_vld_q;
  assign pick_ctrl.skip  = emitted_q[cmp_idx_q];
  assign pick_ctrl.by_x  = !color_q;

  sls_pick #(
    .IW (IW)
  ) u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (pick_ctrl),
    .cand_idx_i  (cmp_idx_q),
    .cand_i      (rd_entry),
    .best_idx_o  (best_idx),
    .best_o      (best),
    .have_best_o (have_best)
  );

  always_ff @(posedge clk_i) begin
    if (load_empty) begin
      any_q    <= 1'b0;
      y_q      <= '0;
      x_q      <= '0;
      tile_q   <= '0;
      behind_q <= 1'b0;
      flipv_q  <= 1'b0;
      fliph_q  <= 1'b0;
      pal_q    <= '0;
      bank_q   <= 1'b0;
      last_q   <= 1'b1;
    end else if (load_out) begin
      any_q    <= 1'b1;
      y_q      <= best.y;
      x_q      <= best.x;
      tile_q   <= best.tile;
      behind_q <= best.attrs[7];
      flipv_q  <= best.attrs[6];
      fliph_q  <= best.attrs[5];
      pal_q    <= color_q ? best.attrs[2:0] : {2'b00, best.attrs[4]};
      bank_q   <= color_q ? best.attrs[3] : 1'b0;
      last_q   <= (rem_q == CW'(1));
    end
  end

  assign out_valid_o       = out_valid_q;
  assign any_sprite_o      = any_q;
  assign sprite_y_o        = y_q;
  assign sprite_x_o        = x_q;
  assign tile_num_o        = tile_q;
  assign bg_priority_o     = behind_q;
  assign flip_vertical_o   = flipv_q;
  assign flip_horizontal_o = fliph_q;
  assign palette_number_o  = pal_q;
  assign bank_number_o     = bank_q;
  assign last_sprite_o     = last_q;

  `SLS_ASSERT_NOW(a_no_accept_while_out, in_ready_o, !out_valid_o, "input taken with result pending")
  `SLS_ASSERT_NOW(a_kept_le_hit, 1'b1, kept_q <= hit_q, "more kept sprites than hits")
  `SLS_ASSERT_NOW(a_load_has_best, state_q == ST_LOAD, have_best, "no sprite picked at load")
  `SLS_ASSERT_NEXT(a_more_results, out_fire && !last_q, !in_ready_o && !out_valid_o, "scan ended early")

endmodule

@@ design/sls_ram.sv @@
module sls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 10,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/sls_pick.sv @@
module sls_pick import sls_pkg::*; #(
  parameter int IW = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pick_ctrl_t ctrl_i,
  input  logic [IW-1:0] cand_idx_i,
  input  sprite_t    cand_i,
  output logic [IW-1:0] best_idx_o,
  output sprite_t    best_o,
  output logic       have_best_o
);

  logic          have_q, have_d;
  logic [IW-1:0] idx_q;
  sprite_t       best_q;
  logic          take;

  // Strict greater keeps the earlier candidate, the higher table slot, on a tie.
  assign take = ctrl_i.vld && !ctrl_i.skip &&
                (!have_q || (ctrl_i.by_x && (cand_i.x > best_q.x)));

  always_comb begin
    have_d = have_q;
    if (ctrl_i.clear) begin
      have_d = 1'b0;
    end else if (take) begin
      have_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !ctrl_i.clear) begin
      idx_q  <= cand_idx_i;
      best_q <= cand_i;
    end
  end

  assign best_idx_o  = idx_q;
  assign best_o      = best_q;
  assign have_best_o = have_q;

endmodule

@@ test/sprite_line_selector_test.sv @@
module sprite_line_selector_test import sls_pkg::*; ();

  localparam int MaxPerLine   = 10;
  localparam int RowLimit     = 160;
  localparam int XLimit       = 168;
  localparam int TallSpan     = 16;
  localparam int ShortGap     = 8;
  localparam bit [7:0] TileMask = 8'hFE;
  localparam int IdleLimit    = 5000;
  localparam int DrainCycles  = 40;
  localparam int HoldCycles   = 400;
  localparam int HoldAfter    = 40;
  localparam int ItemsPerPhase = 48;
  localparam int NumPhases    = 8;
  localparam int MaxPrinted   = 50;

  typedef struct {
    bit [7:0] line;
    bit [7:0] y;
    bit [7:0] x;
    bit [7:0] tile;
    bit [7:0] attrs;
    bit       last;
  } entry_t;

  typedef struct packed {
    bit [7:0] y;
    bit [7:0] x;
    bit [7:0] tile;
    bit [7:0] attrs;
  } kept_t;

  typedef struct packed {
    bit       any_spr;
    bit [7:0] y;
    bit [7:0] x;
    bit [7:0] tile;
    bit       behind;
    bit       flip_v;
    bit       flip_h;
    bit [2:0] pal;
    bit       bank;
    bit       last;
  } beat_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic       cfg_idx_i     = 1'b0;
  logic       cfg_data_i    = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [7:0] line_i        = '0;
  logic [7:0] entry_y_i     = '0;
  logic [7:0] entry_x_i     = '0;
  logic [7:0] entry_tile_i  = '0;
  logic [7:0] entry_attrs_i = '0;
  logic       last_entry_i  = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic       any_sprite_o;
  logic [7:0] sprite_y_o;
  logic [7:0] sprite_x_o;
  logic [7:0] tile_num_o;
  logic       bg_priority_o;
  logic       flip_vertical_o;
  logic       flip_horizontal_o;
  logic [2:0] palette_number_o;
  logic       bank_number_o;
  logic       last_sprite_o;

  sprite_line_selector u_dut (.*);

  always #5 clk_i = ~clk_i;

  // selector state mirrored in the testbench
  bit     tall_cfg;
  bit     color_cfg;
  kept_t  kept_q[$];
  int     hit_count;

  entry_t pend_q[$];
  beat_t  beat_q[$];
  int     items_queued;
  int     items_taken;
  int     err_count;

  task automatic report_mismatch(input string msg);
    if (err_count < MaxPrinted) $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // Apply one table entry to the selection; on the final entry emit the draw list.
  task automatic select_entry(input entry_t e);
    int    gap;
    int    i;
    int    j;
    kept_t k;
    kept_t t;
    kept_t order[$];
    beat_t b;
    gap = tall_cfg ? 0 : ShortGap;
    if (hit_count < MaxPerLine && int'(e.y) > gap && int'(e.y) < RowLimit &&
        int'(e.line) < int'(e.y) - gap && int'(e.line) + TallSpan >= int'(e.y)) begin
      hit_count++;
      if (e.x != 0 && int'(e.x) < XLimit) begin
        k.y     = e.y;
        k.x     = e.x;
        k.tile  = tall_cfg ? (e.tile & TileMask) : e.tile;
        k.attrs = e.attrs;
        kept_q.push_back(k);
      end
    end
    if (!e.last) return;
    hit_count = 0;
    if (kept_q.size() == 0) begin
      b = '0;
      b.last = 1'b1;
      beat_q.push_back(b);
      return;
    end
    for (i = kept_q.size() - 1; i >= 0; i--) order.push_back(kept_q[i]);
    // classic mode: stable sort by descending X
    if (!color_cfg) begin
      for (i = 1; i < order.size(); i++) begin
        t = order[i];
        j = i - 1;
        while (j >= 0 && order[j].x < t.x) begin
          order[j + 1] = order[j];
          j--;
        end
        order[j + 1] = t;
      end
    end
    for (i = 0; i < order.size(); i++) begin
      b.any_spr = 1'b1;
      b.y       = order[i].y;
      b.x       = order[i].x;
      b.tile    = order[i].tile;
      b.behind  = order[i].attrs[7];
      b.flip_v  = order[i].attrs[6];
      b.flip_h  = order[i].attrs[5];
      if (color_cfg) begin
        b.pal  = order[i].attrs[2:0];
        b.bank = order[i].attrs[3];
      end else begin
        b.pal  = {2'b00, order[i].attrs[4]};
        b.bank = 1'b0;
      end
      b.last = (i == order.size() - 1);
      beat_q.push_back(b);
    end
    kept_q = {};
  endtask

  // Driver: bursts of beats separated by random gaps.
  entry_t cur_entry;
  int     burst_left;
  int     gap_left;
  bit     in_take;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      line_i        <= '0;
      entry_y_i     <= '0;
      entry_x_i     <= '0;
      entry_tile_i  <= '0;
      entry_attrs_i <= '0;
      last_entry_i  <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      in_take = in_valid_i && in_ready_o;
      if (in_take) begin
        select_entry(cur_entry);
        items_taken++;
      end
      if (!in_valid_i || in_take) begin
        if (gap_left > 0 || pend_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          cur_entry = pend_q.pop_front();
          line_i        <= cur_entry.line;
          entry_y_i     <= cur_entry.y;
          entry_x_i     <= cur_entry.x;
          entry_tile_i  <= cur_entry.tile;
          entry_attrs_i <= cur_entry.attrs;
          last_entry_i  <= cur_entry.last;
          in_valid_i    <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Monitor: check each result beat, stall on a rotating pattern, one long hold-off.
  beat_t    got;
  beat_t    want;
  bit [7:0] ready_pat;
  int       pat_age;
  int       hold_left;
  bit       hold_done;
  int       results_seen;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_pat = 8'hFF;
      pat_age   = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        got = {any_sprite_o, sprite_y_o, sprite_x_o, tile_num_o, bg_priority_o,
               flip_vertical_o, flip_horizontal_o, palette_number_o, bank_number_o,
               last_sprite_o};
        if (beat_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: %h", got));
        end else begin
          want = beat_q.pop_front();
          check_field("any_sprite", got.any_spr, want.any_spr);
          check_field("sprite_y", got.y, want.y);
          check_field("sprite_x", got.x, want.x);
          check_field("tile_num", got.tile, want.tile);
          check_field("bg_priority", got.behind, want.behind);
          check_field("flip_vertical", got.flip_v, want.flip_v);
          check_field("flip_horizontal", got.flip_h, want.flip_h);
          check_field("palette_number", got.pal, want.pal);
          check_field("bank_number", got.bank, want.bank);
          check_field("last_sprite", got.last, want.last);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && results_seen >= HoldAfter) begin
        // hold off long enough for the input side to back up
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_ready_i <= 1'b0;
      end else begin
        if (pat_age == 0) begin
          ready_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
          if (ready_pat == 8'h00) ready_pat = 8'h01;
          pat_age = $urandom_range(16, 96);
        end
        pat_age--;
        ready_pat = {ready_pat[0], ready_pat[7:1]};
        out_ready_i <= ready_pat[0];
      end
    end
  end

  // Watchdog: end the run if no beat moves for too long.
  int idle_cycles;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_entry(input int line, input int y, input int x, input int tile,
                            input int attrs, input bit last);
    entry_t e;
    e.line  = 8'(line);
    e.y     = 8'(y);
    e.x     = 8'(x);
    e.tile  = 8'(tile);
    e.attrs = 8'(attrs);
    e.last  = last;
    pend_q.push_back(e);
    items_queued++;
  endtask

  task automatic write_cfg(input bit tall, input bit color);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TALL;
    cfg_data_i <= tall;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_COLOR;
    cfg_data_i <= color;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tall_cfg  = tall;
    color_cfg = color;
  endtask

  task automatic drain();
    while (items_taken != items_queued || beat_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One scan: mostly covering entries around a base line, some noise and near misses.
  task automatic gen_scan(input bit tall);
    int n;
    int gap;
    int base;
    int line;
    int y;
    int x;
    gap  = tall ? 0 : ShortGap;
    n    = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 14);
    base = $urandom_range(0, 153);
    for (int i = 0; i < n; i++) begin
      line = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 153) : base;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: y = line + gap + 1 + $urandom_range(0, TallSpan - 1 - gap);
        6, 7:             y = $urandom_range(0, 255);
        default: begin
          case ($urandom_range(0, 3))
            0:       y = line + gap;
            1:       y = line + TallSpan + 1;
            2:       y = gap;
            default: y = RowLimit;
          endcase
        end
      endcase
      case ($urandom_range(0, 9))
        7:       x = 0;
        8:       x = $urandom_range(XLimit, 255);
        9:       x = 8 + 76 * $urandom_range(0, 2);
        default: x = $urandom_range(1, XLimit - 1);
      endcase
      push_entry(line, y, x, $urandom_range(0, 255), $urandom_range(0, 255), i == n - 1);
    end
  endtask

  initial begin : stimulus
    int phase;
    int target;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_cfg(1'b0, 1'b0);

    // line 0: hits at both ends of the Y range, hidden X at 0 and 168, misses, tie on X
    push_entry(0, 9, 8, 8'hFF, 8'hFF, 1'b0);
    push_entry(0, 16, 167, 8'h00, 8'h00, 1'b0);
    push_entry(0, 8, 50, 8'h01, 8'h10, 1'b0);
    push_entry(0, 10, 0, 8'h02, 8'h20, 1'b0);
    push_entry(0, 12, 168, 8'h03, 8'h40, 1'b0);
    push_entry(0, 255, 255, 8'hFF, 8'hFF, 1'b0);
    push_entry(0, 16, 8, 8'h81, 8'h9F, 1'b1);
    // empty line
    push_entry(153, 160, 80, 8'h55, 8'hAA, 1'b0);
    push_entry(153, 0, 0, 8'h00, 8'h00, 1'b1);
    // full selection: entries past the tenth hit are ignored
    for (int i = 0; i < 11; i++) push_entry(100, 109 + i % 8, 20 + 40 * (i % 4), i, i * 23, 1'b0);
    push_entry(100, 110, 60, 8'h77, 8'hEE, 1'b1);
    drain();

    for (phase = 0; phase < NumPhases; phase++) begin
      if (phase < 4) write_cfg(phase[0], phase[1]);
      else write_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      target = items_queued + ItemsPerPhase;
      while (items_queued < target) gen_scan(tall_cfg);
      drain();
    end

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
